FILE: hdl/rafs_pkg.sv
// Package for the room allocator with free stack.
// Event/result payload types, fault and event codes, controller states.
// No dependencies.
`default_nettype none

package rafs_pkg;

    localparam int CUST_W  = 10;
    localparam int ROOM_W  = 11;
    localparam int FAULT_W = 2;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_DEPART = 1'b1;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_OK       = 2'd0,
        FAULT_NO_ROOM  = 2'd1,
        FAULT_NOT_HELD = 2'd2
    } t_fault;

    typedef struct packed {
        logic              func;
        logic [CUST_W-1:0] customer;
    } t_event;

    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [ROOM_W-1:0] occupied;
        logic [ROOM_W-1:0] peak;
        t_fault            fault;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hdl/rafs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/rafs_ctrl.sv
// Controller of the room allocator: clear pass, accept, execute.
// Depends on rafs_pkg.
`default_nettype none

module rafs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire rafs_pkg::t_dp_sts i_sts,
    output rafs_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy
);

    import rafs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    a_look_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> (r_state == ST_IDLE))
        else $error("execute state lasted more than one cycle");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_LOOK))
        else $error("accepted event not executed");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec)
        else $error("back-to-back execute");

endmodule

`default_nettype wire

FILE: hdl/rafs_dp.sv
// Datapath of the room allocator: customer table, free stack, counters, result.
// Depends on rafs_pkg and rafs_ram.
`default_nettype none

module rafs_dp #(
    parameter int MAX_CUSTOMERS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rafs_pkg::t_dp_cmd i_cmd,
    input  wire rafs_pkg::t_event  i_event,
    output rafs_pkg::t_dp_sts      o_sts,
    output rafs_pkg::t_result      o_result,
    output logic                   o_strobe
);

    import rafs_pkg::*;

    localparam int AW = $clog2(MAX_CUSTOMERS);
    localparam int CW = $clog2(MAX_CUSTOMERS + 1);
    localparam int NW = $clog2(MAX_CUSTOMERS + 2);
    localparam int TW = CW + 1;

    logic              r_func;
    logic [CUST_W-1:0] r_cust;
    logic              r_in_range;
    logic [CW-1:0]     r_freed, n_freed;
    logic [NW-1:0]     r_next, n_next;
    logic [CW-1:0]     r_occ, n_occ;
    logic [CW-1:0]     r_peak, n_peak;
    logic [AW-1:0]     r_clr_addr;
    t_result           r_res;
    logic              r_strobe;

    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [TW-1:0] tbl_wdata;
    logic [TW-1:0] tbl_rdata;
    logic          stk_we;
    logic [CW-1:0] stk_rdata;
    logic [CW-1:0] room;
    t_fault        fault;
    logic          alloc;
    logic          hold;
    logic [CW-1:0] held_room;

    assign hold      = tbl_rdata[CW];
    assign held_room = tbl_rdata[CW-1:0];

    rafs_ram #(.WIDTH(TW), .DEPTH(MAX_CUSTOMERS)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (AW'(i_event.customer)),
        .o_rdata (tbl_rdata)
    );

    rafs_ram #(.WIDTH(CW), .DEPTH(MAX_CUSTOMERS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (AW'(r_freed)),
        .i_wdata (held_room),
        .i_re    (i_cmd.load),
        .i_raddr (AW'(r_freed - CW'(1))),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_freed = r_freed;
        n_next  = r_next;
        n_occ   = r_occ;
        n_peak  = r_peak;
        room    = '0;
        fault   = FAULT_OK;
        alloc   = 1'b0;
        stk_we  = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = AW'(r_cust);
        tbl_wdata = '0;
        if (r_func == FUNC_ARRIVE) begin
            priority if (!r_in_range) begin
                fault = FAULT_NO_ROOM;
            end else if (hold) begin
                room = held_room;
            end else if (r_freed != '0) begin
                room    = stk_rdata;
                n_freed = r_freed - CW'(1);
                alloc   = 1'b1;
            end else if (r_next <= NW'(MAX_CUSTOMERS)) begin
                room   = CW'(r_next);
                n_next = r_next + NW'(1);
                alloc  = 1'b1;
            end else begin
                fault = FAULT_NO_ROOM;
            end
            if (alloc) begin
                tbl_we    = i_cmd.exec;
                tbl_wdata = {1'b1, room};
                n_occ     = r_occ + CW'(1);
                if (n_occ > r_peak) begin
                    n_peak = n_occ;
                end
            end
        end else begin
            if (r_in_range && hold && r_freed < CW'(MAX_CUSTOMERS) && r_occ != '0) begin
                room      = held_room;
                tbl_we    = i_cmd.exec;
                tbl_wdata = {1'b0, held_room};
                stk_we    = i_cmd.exec;
                n_freed   = r_freed + CW'(1);
                n_occ     = r_occ - CW'(1);
            end else begin
                fault = FAULT_NOT_HELD;
            end
        end
        if (i_cmd.clear) begin
            tbl_we    = 1'b1;
            tbl_waddr = r_clr_addr;
            tbl_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freed    <= '0;
            r_next     <= NW'(1);
            r_occ      <= '0;
            r_peak     <= '0;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.exec) begin
                r_freed <= n_freed;
                r_next  <= n_next;
                r_occ   <= n_occ;
                r_peak  <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_event.func;
            r_cust     <= i_event.customer;
            r_in_range <= (32'(i_event.customer) < MAX_CUSTOMERS);
        end
        if (i_cmd.exec) begin
            r_res.room     <= ROOM_W'(room);
            r_res.occupied <= ROOM_W'(n_occ);
            r_res.peak     <= ROOM_W'(n_peak);
            r_res.fault    <= fault;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == AW'(MAX_CUSTOMERS - 1));
    assign o_result         = r_res;
    assign o_strobe         = r_strobe;

    a_occ_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_peak)
        else $error("occupancy above peak");

    a_rooms_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) + 32'(r_freed) + 32'd1 == 32'(r_next))
        else $error("issued rooms not split between occupied and free stack");

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.exec))
        else $error("result strobe without execute");

    a_fault_room_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.fault != FAULT_OK) |-> (r_res.room == '0))
        else $error("faulted transfer carries a room");

endmodule

`default_nettype wire

FILE: hdl/room_allocator_free_stack.sv
// Top level of the room allocator with free stack.
// Depends on rafs_pkg, rafs_ctrl, rafs_dp (and rafs_ram through rafs_dp).
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   event in | start, busy         | i_event  (func, customer)
//   result   | o_strobe (1 cycle)  | o_result (room, occupied, peak, fault)
//
// For each event, table and stack are read at the accepting edge
// (registered RAM read), decided and written back in the following cycle.
// busy is low again in the cycle the result strobe is high, so a new event
// may be accepted then. After reset a clearing pass zeroes the customer
// table with busy high. The receiver cannot stall.
`default_nettype none

module room_allocator_free_stack #(
    parameter int MAX_CUSTOMERS = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rafs_pkg::t_event i_event,
    output rafs_pkg::t_result     o_result,
    output logic                  o_strobe
);

    import rafs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rafs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rafs_dp #(.MAX_CUSTOMERS(MAX_CUSTOMERS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_event  (i_event),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

`default_nettype wire
